// File: rtl/depq_pkg.sv
package depq_pkg;
    localparam int CAPACITY    = 4096;
    localparam int AMOUNT_BITS = 20;
    localparam int ADDR_BITS   = $clog2(CAPACITY);
    localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
    localparam int TOTAL_BITS  = 64;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_CLOSE  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    typedef logic [AMOUNT_BITS-1:0] t_amount;
    typedef logic [ADDR_BITS-1:0]   t_addr;
    typedef logic [COUNT_BITS-1:0]  t_count;

    // One request to the shared compare unit.
    typedef struct packed {
        logic    valid;
        logic    want_max;
        logic    first;
        t_amount value;
        t_addr   index;
    } t_cmp_req;

    typedef struct packed {
        t_amount best;
        t_addr   best_index;
    } t_cmp_res;
endpackage

// File: rtl/depq_cmp.sv
module depq_cmp
    import depq_pkg::*;
(
    input  logic     i_clk,
    input  t_cmp_req i_req,
    output t_cmp_res o_res
);
    t_amount r_best;
    t_addr   r_idx;
    logic    w_take;

    // Strict comparison keeps the earliest position on ties.
    always_comb begin
        if (i_req.first) begin
            w_take = 1'b1;
        end else if (i_req.want_max) begin
            w_take = i_req.value > r_best;
        end else begin
            w_take = i_req.value < r_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && w_take) begin
            r_best <= i_req.value;
            r_idx  <= i_req.index;
        end
    end

    assign o_res.best       = r_best;
    assign o_res.best_index = r_idx;
endmodule

// File: rtl/double_ended_priority_queue_spread.sv
// Bounded double-ended queue of amounts with a running spread total. A request
// is taken when i_start is high and o_busy is low; exactly one result follows,
// shown for one cycle with o_done high, and the receiver cannot stall it.
// An insert, clear or unused opcode goes straight to its result. A close
// with N held amounts scans the store twice through one shared comparator,
// one memory read per cycle, and after each scan writes the last entry into
// the hole left by the amount it found; a close with fewer than 2 does nothing.
module double_ended_priority_queue_spread
    import depq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [1:0]             i_opcode,
    input  logic [AMOUNT_BITS-1:0] i_amount,
    output logic                   o_busy,
    output logic                   o_done,
    output logic [TOTAL_BITS-1:0]  o_running_total,
    output logic [AMOUNT_BITS-1:0] o_removed_high,
    output logic [AMOUNT_BITS-1:0] o_removed_low,
    output logic                   o_pair_removed,
    output logic                   o_insert_dropped,
    output logic [12:0]            o_held_count
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;  // issue reads, compare
    localparam logic [3:0] S_DRAIN = 4'd2;  // last read data into comparator
    localparam logic [3:0] S_RDLST = 4'd3;  // read last entry
    localparam logic [3:0] S_WAIT  = 4'd4;
    localparam logic [3:0] S_FILL  = 4'd5;  // write last entry into hole
    localparam logic [3:0] S_DONE  = 4'd6;

    logic [3:0]    r_state;
    t_count        r_count;
    logic [TOTAL_BITS-1:0] r_total;
    t_addr         r_rd_idx;   // address issued this cycle
    t_addr         r_dat_idx;  // address of data in r_rd_data
    logic          r_dat_vld;
    logic          r_dat_first;
    logic          r_pass;     // 0 finds max, 1 finds min
    t_amount       r_hi;
    t_amount       r_lo;
    t_amount       r_rd_data;
    t_amount       r_mem [CAPACITY];

    t_cmp_req w_req;
    t_cmp_res w_res;
    logic     w_we;
    t_addr    w_waddr;
    t_amount  w_wdata;
    t_addr    w_raddr;
    t_addr    w_last;

    assign w_last = r_count[ADDR_BITS-1:0] - t_addr'(1);

    assign w_req.valid    = r_dat_vld;
    assign w_req.want_max = ~r_pass;
    assign w_req.first    = r_dat_first;
    assign w_req.value    = r_rd_data;
    assign w_req.index    = r_dat_idx;

    depq_cmp u_cmp (
        .i_clk (i_clk),
        .i_req (w_req),
        .o_res (w_res)
    );

    always_comb begin
        w_raddr = (r_state == S_RDLST) ? w_last : r_rd_idx;
        w_we    = 1'b0;
        w_waddr = r_count[ADDR_BITS-1:0];
        w_wdata = i_amount;
        if (r_state == S_IDLE && i_start && i_opcode == OP_INSERT
                && r_count < t_count'(CAPACITY)) begin
            w_we = 1'b1;
        end else if (r_state == S_FILL) begin
            w_we    = 1'b1;
            w_waddr = w_res.best_index;
            w_wdata = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_count          <= '0;
            r_total          <= '0;
            r_dat_vld        <= 1'b0;
            r_dat_first      <= 1'b0;
            r_pass           <= 1'b0;
            o_done           <= 1'b0;
            r_rd_idx         <= '0;
            r_dat_idx        <= '0;
            r_hi             <= '0;
            r_lo             <= '0;
            o_running_total  <= '0;
            o_removed_high   <= '0;
            o_removed_low    <= '0;
            o_pair_removed   <= 1'b0;
            o_insert_dropped <= 1'b0;
            o_held_count     <= '0;
        end else begin
            o_done    <= 1'b0;
            r_dat_vld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        o_removed_high   <= '0;
                        o_removed_low    <= '0;
                        o_pair_removed   <= 1'b0;
                        o_insert_dropped <= 1'b0;
                        r_state          <= S_DONE;
                        case (i_opcode)
                            OP_INSERT: begin
                                if (r_count < t_count'(CAPACITY)) begin
                                    r_count <= r_count + t_count'(1);
                                end else begin
                                    o_insert_dropped <= 1'b1;
                                end
                            end
                            OP_CLOSE: begin
                                if (r_count >= t_count'(2)) begin
                                    r_pass   <= 1'b0;
                                    r_rd_idx <= '0;
                                    r_state  <= S_SCAN;
                                end
                            end
                            OP_CLEAR: begin
                                r_count <= '0;
                                r_total <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_dat_vld   <= 1'b1;
                    r_dat_idx   <= r_rd_idx;
                    r_dat_first <= (r_rd_idx == '0);
                    if (r_rd_idx == w_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_rd_idx <= r_rd_idx + t_addr'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_RDLST;
                end
                S_RDLST: begin
                    if (r_pass) begin
                        r_lo <= w_res.best;
                    end else begin
                        r_hi <= w_res.best;
                    end
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    r_state <= S_FILL;
                end
                S_FILL: begin
                    r_count  <= r_count - t_count'(1);
                    r_rd_idx <= '0;
                    if (!r_pass) begin
                        r_pass  <= 1'b1;
                        r_state <= S_SCAN;
                    end else begin
                        r_total        <= r_total + TOTAL_BITS'(r_hi) - TOTAL_BITS'(r_lo);
                        o_removed_high <= r_hi;
                        o_removed_low  <= r_lo;
                        o_pair_removed <= 1'b1;
                        r_state        <= S_DONE;
                    end
                end
                S_DONE: begin
                    o_done          <= 1'b1;
                    o_running_total <= r_total;
                    o_held_count    <= 13'(r_count);
                    r_state         <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);

    // A result never appears without a request having been finished.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state) == S_DONE)
        else $error("result without completed request");

    // The held count never exceeds the store.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(CAPACITY))
        else $error("count overflow");

    // A close pair always has high not below low.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_pair_removed) |-> o_removed_high >= o_removed_low)
        else $error("removed pair out of order");
endmodule
